### hdl/mx4alu_pkg.sv
// Shared types and constants for the matrix ALU.
// Holds the Q16.16 format, operation codes and the control bundles
// passed between the top level and the arithmetic pipeline.
package mx4alu_pkg;

  localparam int QW        = 32;
  localparam int FRAC_BITS = 16;
  localparam int OP_W      = 3;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [OP_W-1:0]      op_t;

  localparam op_t OP_MUL = 3'd0;
  localparam op_t OP_ADD = 3'd1;
  localparam op_t OP_SUB = 3'd2;
  localparam op_t OP_NEG = 3'd3;
  localparam op_t OP_CMP = 3'd4;

  // Control that travels with one memory read through the pipeline.
  typedef struct packed {
    logic valid;
    logic first;  // restart the accumulator with this term
    logic emit;   // this term completes a result
    logic last;   // final result of the run
  } step_ctrl_t;

  // One result leaving the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
    logic all_equal;
    q_t   value;
  } result_t;

endpackage

### hdl/mx4alu_ram.sv
// Single-port-write, single-port-read element memory, registered read.
// Element width comes from mx4alu_pkg.
module mx4alu_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  mx4alu_pkg::q_t        wdata,
  input  logic [AW-1:0]         raddr,
  output mx4alu_pkg::q_t        rdata
);

  mx4alu_pkg::q_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/mx4alu_mac.sv
// Three-stage arithmetic pipeline: multiply, add, subtract or negate, round
// and saturate, then saturating accumulate with a running equality flag. Uses mx4alu_pkg.
module mx4alu_mac (
  input  logic                   clk,
  input  logic                   rst,
  input  mx4alu_pkg::op_t        op,
  input  mx4alu_pkg::step_ctrl_t ctrl_in,
  input  mx4alu_pkg::q_t         a,
  input  mx4alu_pkg::q_t         b,
  output mx4alu_pkg::result_t    res
);

  localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (mx4alu_pkg::FRAC_BITS - 1);

  function automatic mx4alu_pkg::q_t sat33(input logic signed [32:0] v);
    mx4alu_pkg::q_t r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic mx4alu_pkg::q_t sat64(input logic signed [63:0] v);
    mx4alu_pkg::q_t r;
    if ((&v[63:31]) || !(|v[63:31])) begin
      r = v[31:0];
    end else begin
      r = v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // stage 1
  mx4alu_pkg::step_ctrl_t ctrl1;
  logic signed [63:0]     prod;
  logic signed [32:0]     sum1;
  logic                   eq1;
  // stage 2
  mx4alu_pkg::step_ctrl_t ctrl2;
  mx4alu_pkg::q_t         term;
  logic                   eq2;
  // stage 3
  mx4alu_pkg::q_t         acc;
  logic                   eq_acc;
  logic                   res_valid;
  logic                   res_last;

  logic signed [32:0] sum1_next;
  logic signed [63:0] rounded;
  logic signed [63:0] shifted;
  logic signed [32:0] acc_sum;

  always_comb begin
    unique case (op)
      mx4alu_pkg::OP_ADD: sum1_next = {a[31], a} + {b[31], b};
      mx4alu_pkg::OP_SUB: sum1_next = {a[31], a} - {b[31], b};
      mx4alu_pkg::OP_NEG: sum1_next = 33'sd0 - {a[31], a};
      default:            sum1_next = 33'sd0;
    endcase
  end

  assign rounded = prod + HALF_LSB;
  assign shifted = rounded >>> mx4alu_pkg::FRAC_BITS;
  assign acc_sum = ctrl2.first ? {term[31], term} : ({acc[31], acc} + {term[31], term});

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1     <= '0;
      ctrl2     <= '0;
      res_valid <= 1'b0;
      res_last  <= 1'b0;
    end else begin
      ctrl1     <= ctrl_in;
      ctrl2     <= ctrl1;
      res_valid <= ctrl2.valid & ctrl2.emit;
      res_last  <= ctrl2.last;
    end
    prod <= 64'(a) * 64'(b);
    sum1 <= sum1_next;
    eq1  <= (a == b);
    term <= (op == mx4alu_pkg::OP_MUL) ? sat64(shifted) : sat33(sum1);
    eq2  <= eq1;
    if (ctrl2.valid) begin
      acc    <= sat33(acc_sum);
      eq_acc <= ctrl2.first ? eq2 : (eq_acc & eq2);
    end
  end

  assign res.valid     = res_valid;
  assign res.last      = res_last;
  assign res.all_equal = (op == mx4alu_pkg::OP_CMP) ? eq_acc : 1'b0;
  assign res.value     = (op == mx4alu_pkg::OP_CMP) ? 32'sd0 : acc;

endmodule

### hdl/matrix4_alu_top.sv
// Matrix ALU: load DIM x DIM matrices A and B, then multiply, add, subtract,
// negate or compare them in signed Q16.16 with saturation.
// A multiply run starts the cycle after the final pair. Each run takes
// DIM*DIM*DIM multiply steps on the one shared pipeline (DIM*DIM steps
// otherwise), and load_stall holds new pairs off until its last step is issued.
// Reset (rst, synchronous): clears load count, mode to multiply, queue empty.
module matrix4_alu_top #(
  parameter int DIM = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: operation register
  input  logic                        cfg_wr_en,
  input  logic [mx4alu_pkg::OP_W-1:0] cfg_wr_data,
  // load channel
  input  logic                        load_valid,
  output logic                        load_stall,
  input  logic signed [31:0]          a_element,
  input  logic signed [31:0]          b_element,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [31:0]          value,
  output logic                        all_equal,
  output logic                        last
);

  localparam int ELEMS      = DIM * DIM;
  localparam int AW         = (ELEMS > 1) ? $clog2(ELEMS) : 1;
  localparam int IW         = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PW         = $clog2(FIFO_DEPTH);
  localparam int CW         = $clog2(FIFO_DEPTH + 1);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                  state;
  mx4alu_pkg::op_t       operation;
  mx4alu_pkg::op_t       run_op;
  logic [AW-1:0]         load_count;
  logic [IW-1:0]         row;
  logic [IW-1:0]         col;
  logic [IW-1:0]         kk;
  logic [CW-1:0]         reserved;
  logic [CW-1:0]         reserved_next;

  logic                  load_fire;
  logic                  load_done;
  logic                  is_mul;
  logic                  is_cmp;
  logic                  row_end;
  logic                  col_end;
  logic                  k_end;
  logic                  step_first;
  logic                  step_emit;
  logic                  step_last;
  logic                  issue;
  logic [AW-1:0]         a_raddr;
  logic [AW-1:0]         b_raddr;
  mx4alu_pkg::q_t        a_rdata;
  mx4alu_pkg::q_t        b_rdata;
  mx4alu_pkg::step_ctrl_t issue_ctrl;
  mx4alu_pkg::step_ctrl_t rd_ctrl;
  mx4alu_pkg::result_t   mac_res;

  // Output queue: decouples the pipeline from a stalled consumer.
  mx4alu_pkg::result_t   fifo_mem [FIFO_DEPTH];
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         rd_ptr;
  logic [CW-1:0]         fifo_count;
  logic                  pop;

  //--------------------------------------------------------------------------
  // Load side. Loads are only taken between runs, so a memory is never
  // written and read for the same run in the same cycle.
  //--------------------------------------------------------------------------
  assign load_stall = (state != ST_LOAD);
  assign load_fire  = load_valid & ~load_stall;
  assign load_done  = load_fire & (load_count == AW'(ELEMS - 1));

  //--------------------------------------------------------------------------
  // Run sequencer: walks row, column and inner index; one memory read each.
  //--------------------------------------------------------------------------
  assign is_mul  = (run_op == mx4alu_pkg::OP_MUL);
  assign is_cmp  = (run_op == mx4alu_pkg::OP_CMP);
  assign row_end = (row == IW'(DIM - 1));
  assign col_end = (col == IW'(DIM - 1));
  assign k_end   = (kk == IW'(DIM - 1));

  assign step_last  = row_end & col_end & (~is_mul | k_end);
  assign step_first = is_mul ? (kk == '0) :
                      (is_cmp ? ((row == '0) & (col == '0)) : 1'b1);
  assign step_emit  = is_mul ? k_end : (is_cmp ? step_last : 1'b1);

  // Hold a result-producing step until a queue slot is reserved for it.
  assign issue = (state == ST_RUN) & (~step_emit | (reserved < CW'(FIFO_DEPTH)));

  assign a_raddr = is_mul ? AW'(int'(row) * DIM + int'(kk)) : AW'(int'(row) * DIM + int'(col));
  assign b_raddr = is_mul ? AW'(int'(kk) * DIM + int'(col)) : AW'(int'(row) * DIM + int'(col));

  assign issue_ctrl.valid = issue;
  assign issue_ctrl.first = step_first;
  assign issue_ctrl.emit  = step_emit;
  assign issue_ctrl.last  = step_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      operation  <= mx4alu_pkg::OP_MUL;
      run_op     <= mx4alu_pkg::OP_MUL;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      kk         <= '0;
      rd_ctrl    <= '0;
    end else begin
      rd_ctrl <= issue_ctrl;
      if (cfg_wr_en) begin
        operation <= cfg_wr_data;
      end
      unique case (state)
        ST_LOAD: begin
          if (load_done) begin
            load_count <= '0;
            run_op     <= operation;
            row        <= '0;
            col        <= '0;
            kk         <= '0;
            // Undefined codes drop the loaded matrices and emit nothing.
            if (operation <= mx4alu_pkg::OP_CMP) begin
              state <= ST_RUN;
            end
          end else if (load_fire) begin
            load_count <= load_count + AW'(1);
          end
        end
        ST_RUN: begin
          if (issue) begin
            if (is_mul & ~k_end) begin
              kk <= kk + IW'(1);
            end else begin
              kk <= '0;
              if (col_end) begin
                col <= '0;
                row <= row + IW'(1);
              end else begin
                col <= col + IW'(1);
              end
            end
            if (step_last) begin
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Element memories and arithmetic pipeline
  //--------------------------------------------------------------------------
  mx4alu_ram #(.DEPTH(ELEMS), .AW(AW)) u_left_ram (
    .clk   (clk),
    .we    (load_fire),
    .waddr (load_count),
    .wdata (a_element),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mx4alu_ram #(.DEPTH(ELEMS), .AW(AW)) u_right_ram (
    .clk   (clk),
    .we    (load_fire),
    .waddr (load_count),
    .wdata (b_element),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mx4alu_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .op      (run_op),
    .ctrl_in (rd_ctrl),
    .a       (a_rdata),
    .b       (b_rdata),
    .res     (mac_res)
  );

  //--------------------------------------------------------------------------
  // Slot reservation and output queue. A slot is taken at issue and freed
  // when the consumer takes the transaction, so the queue never overflows.
  //--------------------------------------------------------------------------
  assign pop          = result_valid & ~result_stall;
  assign result_valid = (fifo_count != '0);

  always_comb begin
    reserved_next = reserved;
    if (issue & step_emit) begin
      reserved_next = reserved_next + CW'(1);
    end
    if (pop) begin
      reserved_next = reserved_next - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved   <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      reserved <= reserved_next;
      if (mac_res.valid) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      fifo_count <= fifo_count + CW'(mac_res.valid) - CW'(pop);
    end
    if (mac_res.valid) begin
      fifo_mem[wr_ptr] <= mac_res;
    end
  end

  assign value     = fifo_mem[rd_ptr].value;
  assign all_equal = fifo_mem[rd_ptr].all_equal;
  assign last      = fifo_mem[rd_ptr].last;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix4_alu_top: streams 4x4 Q16.16 matrix pairs,
// predicts every run's result stream in place and checks it field by field.
// Depends on mx4alu_pkg and matrix4_alu_top only.
module tb_top;

  localparam int N = 4;
  localparam int ELEMS = N * N;
  // Operation codes with no defined behavior; a run under them emits nothing.
  localparam mx4alu_pkg::op_t OP_UNDEF_LO  = 3'd5;
  localparam mx4alu_pkg::op_t OP_UNDEF_MID = 3'd6;
  localparam mx4alu_pkg::op_t OP_UNDEF_HI  = 3'd7;
  localparam mx4alu_pkg::q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam mx4alu_pkg::q_t Q_MIN = 32'sh8000_0000;
  localparam mx4alu_pkg::q_t Q_ONE = 32'sh0001_0000;
  // exactly half a result LSB once multiplied by the raw value 1
  localparam mx4alu_pkg::q_t Q_HALF_LSB = 32'sh0000_8000;
  localparam int SETTLE_CYCLES = 20;
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_PHASES = 3;
  localparam int RUNS_PER_PHASE = 2;
  localparam int MAX_REPORTS = 40;

  // One result transaction as the checker sees it.
  typedef struct packed {
    mx4alu_pkg::q_t value;
    logic           all_equal;
    logic           last;
  } mx_out_t;

  // One directed run: A is filled with a_fill and B with b_fill throughout, bar the one_off flip.
  typedef struct packed {
    mx4alu_pkg::op_t op;
    mx4alu_pkg::q_t  a_fill;
    mx4alu_pkg::q_t  b_fill;
    logic            one_off;    // flip the LSB of the final B element
    logic            typed;      // expectation comes from this row, not from the predictor
    mx4alu_pkg::q_t  exp_value;
    logic            exp_eq;
  } dir_run_t;

  logic            clk;
  logic            rst = 1'b1;
  logic            cfg_wr_en = 1'b0;
  mx4alu_pkg::op_t cfg_wr_data = mx4alu_pkg::OP_MUL;
  logic            load_valid = 1'b0;
  logic            load_stall;
  mx4alu_pkg::q_t  a_element = '0;
  mx4alu_pkg::q_t  b_element = '0;
  logic            result_valid;
  logic            result_stall = 1'b0;
  mx4alu_pkg::q_t  value;
  logic            all_equal;
  logic            last;

  // Predictor state: the two loaded matrices, fill position and mode shadow.
  mx4alu_pkg::q_t  left_m [ELEMS];
  mx4alu_pkg::q_t  right_m [ELEMS];
  int unsigned     fill_count = 0;
  mx4alu_pkg::op_t mode_shadow = mx4alu_pkg::OP_MUL;
  mx_out_t         run_out [$];          // results of the run just completed
  mx_out_t         pending_results [$];  // results still owed by the block

  mx4alu_pkg::q_t a_set [ELEMS];
  mx4alu_pkg::q_t b_set [ELEMS];

  int errors = 0;
  int pairs_loaded = 0;
  int results_checked = 0;
  int runs_by_op [8] = '{default: 0};
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  // Directed runs: saturation corners, rounding ties, every mode, an undefined code.
  dir_run_t dir_runs [11] = '{
    '{mx4alu_pkg::OP_MUL, Q_MAX, Q_MAX, 1'b0, 1'b1, Q_MAX, 1'b0},  // every product clips high
    '{mx4alu_pkg::OP_MUL, Q_MIN, Q_MAX, 1'b0, 1'b1, Q_MIN, 1'b0},  // every product clips low
    '{mx4alu_pkg::OP_MUL, Q_MIN, Q_MIN, 1'b0, 1'b1, Q_MAX, 1'b0},  // min times min clips high
    '{mx4alu_pkg::OP_MUL, 32'sd1, Q_HALF_LSB, 1'b0, 1'b0, '0, 1'b0},  // positive tie rounds up
    '{mx4alu_pkg::OP_MUL, -32'sd1, Q_HALF_LSB, 1'b0, 1'b0, '0, 1'b0}, // negative tie to 0
    '{mx4alu_pkg::OP_ADD, Q_MAX, Q_MAX, 1'b0, 1'b1, Q_MAX, 1'b0},
    '{mx4alu_pkg::OP_SUB, Q_MIN, Q_MAX, 1'b0, 1'b1, Q_MIN, 1'b0},
    '{mx4alu_pkg::OP_NEG, Q_MIN, 32'sh1234_5678, 1'b0, 1'b1, Q_MAX, 1'b0}, // negating min clips
    '{mx4alu_pkg::OP_CMP, Q_MIN, Q_MIN, 1'b0, 1'b1, '0, 1'b1},
    '{mx4alu_pkg::OP_CMP, Q_MAX, Q_MAX, 1'b1, 1'b1, '0, 1'b0},     // one element differs
    '{OP_UNDEF_LO, Q_ONE, Q_ONE, 1'b0, 1'b1, '0, 1'b0}             // run is dropped
  };

  matrix4_alu_top #(.DIM(N)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .load_valid   (load_valid),
    .load_stall   (load_stall),
    .a_element    (a_element),
    .b_element    (b_element),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .all_equal    (all_equal),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Clip a wide intermediate to the signed 32-bit range.
  function automatic mx4alu_pkg::q_t q_sat(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return mx4alu_pkg::q_t'(v);
  endfunction

  // Q16.16 product, rounded to nearest with ties toward +inf, then clipped.
  // The arithmetic shift of a signed value is a floor division.
  function automatic mx4alu_pkg::q_t q_mul_round(mx4alu_pkg::q_t x, mx4alu_pkg::q_t y);
    longint p;
    p = longint'(x) * longint'(y) + (longint'(1) <<< (mx4alu_pkg::FRAC_BITS - 1));
    return q_sat(p >>> mx4alu_pkg::FRAC_BITS);
  endfunction

  // Store one accepted element pair; on the final pair compute the run's results.
  task automatic absorb_pair(input mx4alu_pkg::q_t a, input mx4alu_pkg::q_t b);
    mx4alu_pkg::q_t acc;
    longint         r;
    logic           same;
    left_m[fill_count] = a;
    right_m[fill_count] = b;
    fill_count++;
    if (fill_count < ELEMS) return;
    fill_count = 0;
    runs_by_op[mode_shadow]++;
    case (mode_shadow)
      mx4alu_pkg::OP_MUL: begin
        for (int i = 0; i < N; i++) begin
          for (int j = 0; j < N; j++) begin
            // accumulate k = 0..N-1 in order, clipping after every add
            acc = '0;
            for (int k = 0; k < N; k++)
              acc = q_sat(longint'(acc) +
                          longint'(q_mul_round(left_m[i*N+k], right_m[k*N+j])));
            run_out.push_back('{acc, 1'b0, (i*N + j) == ELEMS - 1});
          end
        end
      end
      mx4alu_pkg::OP_ADD, mx4alu_pkg::OP_SUB, mx4alu_pkg::OP_NEG: begin
        for (int i = 0; i < ELEMS; i++) begin
          if (mode_shadow == mx4alu_pkg::OP_ADD)
            r = longint'(left_m[i]) + longint'(right_m[i]);
          else if (mode_shadow == mx4alu_pkg::OP_SUB)
            r = longint'(left_m[i]) - longint'(right_m[i]);
          else
            r = -longint'(left_m[i]);
          run_out.push_back('{q_sat(r), 1'b0, i == ELEMS - 1});
        end
      end
      mx4alu_pkg::OP_CMP: begin
        same = 1'b1;
        for (int i = 0; i < ELEMS; i++)
          if (left_m[i] != right_m[i]) same = 1'b0;
        run_out.push_back('{mx4alu_pkg::q_t'(0), same, 1'b1});
      end
      default: ;  // undefined code: matrices dropped, nothing emitted
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Load side
  // ---------------------------------------------------------------------------

  // Drive one element pair and hold it until the block takes the transaction.
  // Idle cycles are rolled up front so valid never follows stall.
  task automatic send_pair(input mx4alu_pkg::q_t a, input mx4alu_pkg::q_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      load_valid <= 1'b0;
      @(posedge clk);
    end
    load_valid <= 1'b1;
    a_element <= a;
    b_element <= b;
    do @(posedge clk); while (load_stall);
    pairs_loaded++;
    absorb_pair(a, b);
  endtask

  task automatic load_run();
    for (int e = 0; e < ELEMS; e++) send_pair(a_set[e], b_set[e]);
  endtask

  // Write the operation register with the block idle: drop valid, drain every
  // owed result, let the pipeline settle, then pulse the write enable.
  task automatic set_operation(input mx4alu_pkg::op_t op);
    load_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= op;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_shadow = op;
  endtask

  // Random element: full-range noise most often, plus small values, the extremes,
  // plus or minus one, and single-LSB values.
  function automatic mx4alu_pkg::q_t rand_elem();
    case ($urandom_range(0, 7))
      0, 1, 2: return mx4alu_pkg::q_t'($urandom);
      3, 4:    return mx4alu_pkg::q_t'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
      5:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      6:       return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      default: return mx4alu_pkg::q_t'($signed($urandom_range(0, 2)) - 32'sd1);
    endcase
  endfunction

  // Fill both matrices; in compare mode make B a copy of A in most runs,
  // sometimes with a single bit flipped, so both flag values show up.
  task automatic fill_random_run();
    int flip_elem;
    int flip_bit;
    for (int e = 0; e < ELEMS; e++) begin
      a_set[e] = rand_elem();
      b_set[e] = rand_elem();
    end
    if (mode_shadow == mx4alu_pkg::OP_CMP && $urandom_range(0, 2) != 0) begin
      b_set = a_set;
      if ($urandom_range(0, 1)) begin
        flip_elem = $urandom_range(0, ELEMS - 1);
        flip_bit = $urandom_range(0, 31);
        b_set[flip_elem][flip_bit] = ~b_set[flip_elem][flip_bit];
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall the result channel at random at the current receiver rate.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("tb_top: MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Check each result transaction against the oldest owed result.
  always @(posedge clk) begin : check_results
    mx_out_t owed;
    if (!rst && result_valid && !result_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: value=%h all_equal=%b last=%b",
                                  value, all_equal, last));
      end else begin
        owed = pending_results.pop_front();
        if (value !== owed.value)
          report_mismatch($sformatf("value %h, want %h", value, owed.value));
        if (all_equal !== owed.all_equal)
          report_mismatch($sformatf("all_equal %b, want %b", all_equal, owed.all_equal));
        if (last !== owed.last)
          report_mismatch($sformatf("last %b, want %b", last, owed.last));
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (load_valid && !load_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: no transaction for %0d cycles, %0d results still owed",
               quiet_cycles, pending_results.size());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    dir_run_t        row;
    mx4alu_pkg::op_t op;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed runs with a slow sender and a heavily stalling receiver.
    send_idle_pct = 15;
    recv_idle_pct = 48;
    foreach (dir_runs[r]) begin
      row = dir_runs[r];
      set_operation(row.op);
      for (int e = 0; e < ELEMS; e++) begin
        a_set[e] = row.a_fill;
        b_set[e] = row.b_fill;
      end
      if (row.one_off) b_set[ELEMS-1][0] = ~b_set[ELEMS-1][0];
      load_run();
      // Replace the prediction with the row's own expectation where it has one.
      if (row.typed) begin
        run_out.delete();
        case (row.op)
          mx4alu_pkg::OP_MUL, mx4alu_pkg::OP_ADD, mx4alu_pkg::OP_SUB, mx4alu_pkg::OP_NEG:
            for (int e = 0; e < ELEMS; e++)
              run_out.push_back('{row.exp_value, 1'b0, e == ELEMS - 1});
          mx4alu_pkg::OP_CMP: run_out.push_back('{mx4alu_pkg::q_t'(0), row.exp_eq, 1'b1});
          default: ;
        endcase
      end
      while (run_out.size() != 0) pending_results.push_back(run_out.pop_front());
    end

    // Random phases: one operation per phase, runs back to back within it.
    // Swap the idle rates a third of the way in, then drop idling altogether.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES / 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 15;
      end else if (p == 2 * RAND_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      op = ($urandom_range(0, 5) == 0) ?
           mx4alu_pkg::op_t'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)) :
           mx4alu_pkg::op_t'($urandom_range(mx4alu_pkg::OP_MUL, mx4alu_pkg::OP_CMP));
      set_operation(op);
      repeat (RUNS_PER_PHASE) begin
        fill_random_run();
        load_run();
        while (run_out.size() != 0) pending_results.push_back(run_out.pop_front());
      end
    end

    // Drain, then give the block time to show any stray result.
    load_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb_top: %0d element pairs in %0d matrix runs, %0d results checked, %0d mismatches",
             pairs_loaded, pairs_loaded / ELEMS, results_checked, errors);
    $display("tb_top: runs by mode: mul %0d add %0d sub %0d neg %0d cmp %0d undefined %0d",
             runs_by_op[mx4alu_pkg::OP_MUL], runs_by_op[mx4alu_pkg::OP_ADD],
             runs_by_op[mx4alu_pkg::OP_SUB], runs_by_op[mx4alu_pkg::OP_NEG],
             runs_by_op[mx4alu_pkg::OP_CMP],
             runs_by_op[OP_UNDEF_LO] + runs_by_op[OP_UNDEF_MID] + runs_by_op[OP_UNDEF_HI]);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
